/* design/assert_macros.svh */
// Assertion macros used by the checker file of the convolution unit.
// Each macro expects clk and rst in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that holds at every clock edge outside reset.
`define LCF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Antecedent at one edge implies the consequent at the next edge.
`define LCF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* design/lcf_pkg.sv */
// Shared types and constants of the linear convolution FIR unit.
// No dependencies; imported by every module of the unit.
package lcf_pkg;

  localparam int TAP_COUNT_W      = 7;
  localparam int TAP_INDEX_W      = 6;
  localparam int OUT_WIDTH        = 38;
  localparam int DEF_MAX_TAPS     = 64;
  localparam int DEF_SAMPLE_WIDTH = 16;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_BUSY = 2'b10
  } lcf_state_t;

  // Strobes broadcast from the controller to the cell chain.
  typedef struct packed {
    logic load;
    logic shift;
    logic clear;
  } lcf_ctrl_t;

endpackage

/* design/lcf_cell.sv */
// One tap cell: history sample, coefficient, registered product and the
// partial sum handed to the next cell. Depends on lcf_pkg.
module lcf_cell import lcf_pkg::*; #(
  parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH
) (
  input  logic                           clk,
  input  logic                           rst,
  input  lcf_ctrl_t                      ctrl,
  input  logic                           load,
  input  logic                           active,
  input  logic signed [SAMPLE_WIDTH-1:0] coef_in,
  input  logic signed [SAMPLE_WIDTH-1:0] x_in,
  input  logic signed [OUT_WIDTH-1:0]    psum_in,
  output logic signed [SAMPLE_WIDTH-1:0] x_out,
  output logic signed [OUT_WIDTH-1:0]    psum_out
);

  localparam int PROD_W = 2 * SAMPLE_WIDTH;

  logic signed [SAMPLE_WIDTH-1:0] coef;
  logic signed [SAMPLE_WIDTH-1:0] x;
  logic signed [PROD_W-1:0]       prod_full;
  logic signed [OUT_WIDTH-1:0]    prod_term;
  logic signed [OUT_WIDTH-1:0]    prod;
  logic signed [OUT_WIDTH-1:0]    psum;

  always_ff @(posedge clk) begin
    if (load) begin
      coef <= coef_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      x <= '0;
    end else if (ctrl.clear) begin
      x <= '0;
    end else if (ctrl.shift) begin
      x <= x_in;
    end
  end

  assign prod_full = coef * x;

  // Products wrap or sign-extend to the output width; sums wrap to it as well.
  generate
    if (PROD_W >= OUT_WIDTH) begin : g_wrap
      assign prod_term = prod_full[OUT_WIDTH-1:0];
    end else begin : g_ext
      assign prod_term = {{(OUT_WIDTH-PROD_W){prod_full[PROD_W-1]}}, prod_full};
    end
  endgenerate

  always_ff @(posedge clk) begin
    prod <= prod_term;
    psum <= psum_in + (active ? prod : '0);
  end

  assign x_out    = x;
  assign psum_out = psum;

endmodule

/* design/lcf_ctrl.sv */
// Sequencer of the convolution unit: item intake, sweep timing, tail flush
// and the result beat. Depends on lcf_pkg.
module lcf_ctrl import lcf_pkg::*; #(
  parameter int MAX_TAPS = DEF_MAX_TAPS,
  localparam int TAP_W   = $clog2(MAX_TAPS + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  input  logic             mode,
  input  logic             is_last,
  input  logic [TAP_W-1:0] taps,
  input  logic             result_stall,
  output logic             item_stall,
  output logic             result_valid,
  output logic             out_last,
  output logic             capture,
  output lcf_ctrl_t        ctrl
);

  // Product register plus one partial-sum register per cell.
  localparam int SWEEP = MAX_TAPS + 1;
  localparam int CNT_W = $clog2(SWEEP + 1);

  lcf_state_t       state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic [TAP_W-1:0] flush_left, flush_left_next;
  logic             block_last, block_last_next;
  logic             accept;
  logic             sample_acc;
  logic             out_free;
  logic             more;

  assign accept     = item_valid && (state == ST_IDLE);
  assign sample_acc = accept && mode;
  assign out_free   = !result_valid || !result_stall;
  assign more       = (flush_left != '0);
  assign capture    = (state == ST_BUSY) && (cnt == CNT_W'(SWEEP)) && out_free;
  assign item_stall = (state != ST_IDLE);

  assign ctrl.load  = accept && !mode;
  assign ctrl.shift = sample_acc || (capture && more);
  assign ctrl.clear = capture && !more && block_last;

  always_comb begin
    state_next      = state;
    cnt_next        = cnt;
    flush_left_next = flush_left;
    block_last_next = block_last;
    case (state)
      ST_IDLE: begin
        if (sample_acc) begin
          state_next      = ST_BUSY;
          cnt_next        = '0;
          block_last_next = is_last;
          flush_left_next = is_last ? (taps - TAP_W'(1)) : '0;
        end
      end
      ST_BUSY: begin
        if (capture) begin
          if (more) begin
            // shift in the next tail zero and sweep again
            flush_left_next = flush_left - TAP_W'(1);
            cnt_next        = '0;
          end else begin
            state_next = ST_IDLE;
          end
        end else if (cnt != CNT_W'(SWEEP)) begin
          cnt_next = cnt + CNT_W'(1);
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      cnt          <= '0;
      flush_left   <= '0;
      block_last   <= 1'b0;
      result_valid <= 1'b0;
      out_last     <= 1'b0;
    end else begin
      state      <= state_next;
      cnt        <= cnt_next;
      flush_left <= flush_left_next;
      block_last <= block_last_next;
      if (capture) begin
        result_valid <= 1'b1;
        out_last     <= block_last && !more;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

endmodule

/* design/linear_convolution_fir_unit.sv */
// Top level of the linear convolution FIR unit: tap count register, chain
// of tap cells and the output register. Depends on lcf_pkg, lcf_cell, lcf_ctrl.
//
//   Channel  | Handshake                 | Beat carries
//   ---------+---------------------------+---------------------------------
//   config   | cfg_write                 | cfg_data (tap_count)
//   item     | item_valid / item_stall   | mode, tap_index, data_value, is_last
//   result   | result_valid / result_stall | out_value, out_last
//
// A coefficient load leaves the unit idle. A sample, and each tail output of a
// last sample, runs a sweep: history shift, product register, then the partial
// sum walks through all MAX_TAPS cells.
// Reset is synchronous: history cleared, tap_count = 1, coefficients unset.
// A finished result waits in the output register while the next item enters;
// a stalled result holds the sweep at its end.
module linear_convolution_fir_unit import lcf_pkg::*; #(
  parameter int MAX_TAPS     = DEF_MAX_TAPS,
  parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [TAP_COUNT_W-1:0]         cfg_data,
  input  logic                           item_valid,
  output logic                           item_stall,
  input  logic                           mode,
  input  logic [TAP_INDEX_W-1:0]         tap_index,
  input  logic signed [SAMPLE_WIDTH-1:0] data_value,
  input  logic                           is_last,
  output logic                           result_valid,
  input  logic                           result_stall,
  output logic signed [OUT_WIDTH-1:0]    out_value,
  output logic                           out_last
);

  localparam int TAP_W = $clog2(MAX_TAPS + 1);

  logic [TAP_COUNT_W-1:0]         tap_count;
  logic [TAP_W-1:0]               taps;
  logic                           capture;
  lcf_ctrl_t                      ctrl;
  logic signed [SAMPLE_WIDTH-1:0] x_head;
  logic signed [SAMPLE_WIDTH-1:0] x_link    [MAX_TAPS];
  logic signed [OUT_WIDTH-1:0]    psum_link [MAX_TAPS];

  always_ff @(posedge clk) begin
    if (rst) begin
      tap_count <= TAP_COUNT_W'(1);
    end else if (cfg_write) begin
      tap_count <= cfg_data;
    end
  end

  // Saturate the tap count to 1..MAX_TAPS.
  always_comb begin
    if (tap_count == '0) begin
      taps = TAP_W'(1);
    end else if (tap_count > TAP_COUNT_W'(MAX_TAPS)) begin
      taps = TAP_W'(MAX_TAPS);
    end else begin
      taps = tap_count[TAP_W-1:0];
    end
  end

  lcf_ctrl #(
    .MAX_TAPS (MAX_TAPS)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .mode         (mode),
    .is_last      (is_last),
    .taps         (taps),
    .result_stall (result_stall),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .out_last     (out_last),
    .capture      (capture),
    .ctrl         (ctrl)
  );

  // Shifts while busy are tail flushes: feed zeros.
  assign x_head = item_stall ? '0 : data_value;

  generate
    for (genvar j = 0; j < MAX_TAPS; j++) begin : g_cell
      logic signed [SAMPLE_WIDTH-1:0] x_in;
      logic signed [OUT_WIDTH-1:0]    psum_in;
      logic                           active;
      logic                           load;

      if (j == 0) begin : g_head
        assign x_in    = x_head;
        assign psum_in = '0;
      end else begin : g_body
        assign x_in    = x_link[j-1];
        assign psum_in = psum_link[j-1];
      end

      assign active = (TAP_W'(j) < taps);
      assign load   = ctrl.load && (tap_index == TAP_INDEX_W'(j));

      lcf_cell #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
      ) u_cell (
        .clk      (clk),
        .rst      (rst),
        .ctrl     (ctrl),
        .load     (load),
        .active   (active),
        .coef_in  (data_value),
        .x_in     (x_in),
        .psum_in  (psum_in),
        .x_out    (x_link[j]),
        .psum_out (psum_link[j])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (capture) begin
      out_value <= psum_link[MAX_TAPS-1];
    end
  end

endmodule

/* design/lcf_checker.sv */
// Port-level checks of the linear convolution FIR unit, bound to the top.
// Depends on lcf_pkg and assert_macros.svh.
`include "assert_macros.svh"

module lcf_checker import lcf_pkg::*; (
  input logic                        clk,
  input logic                        rst,
  input logic                        item_valid,
  input logic                        item_stall,
  input logic                        mode,
  input logic                        result_valid,
  input logic                        result_stall,
  input logic signed [OUT_WIDTH-1:0] out_value,
  input logic                        out_last
);

  `LCF_ASSERT_NEXT(a_result_hold, result_valid && result_stall, result_valid && $stable(out_value) && $stable(out_last), "stalled result beat changed")
  `LCF_ASSERT_NEXT(a_sample_busy, item_valid && !item_stall && mode, item_stall, "sample beat did not start a sweep")
  `LCF_ASSERT_NEXT(a_load_quick, item_valid && !item_stall && !mode, !item_stall, "coefficient load left the unit busy")
  `LCF_ASSERT(a_last_idle, ($rose(result_valid) && out_last) |-> !item_stall, "unit still busy after final output")

endmodule

bind linear_convolution_fir_unit lcf_checker u_lcf_checker (.*);
